### rtl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg: shared types and constants of the averaging sweep recorder
// Field widths, operation and register codes, controller/datapath links.
// ----------------------------------------------------------------------------
package asr_pkg;

   localparam int unsigned DEF_SIGNALS = 8;
   localparam int unsigned DEF_POINTS  = 2048;

   localparam int unsigned OP_W       = 3;
   localparam int unsigned SIG_IDX_W  = 3;
   localparam int unsigned VAL_W      = 31;
   localparam int unsigned PIDX_W     = 11;
   localparam int unsigned NPTS_W     = 12;
   localparam int unsigned SPP_W      = 16;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned SUM_W      = 47;
   localparam int unsigned CFG_IDX_W  = 2;
   localparam int unsigned CFG_DATA_W = 32;

   // divider: dividend 2*sum+n, divisor 2*n
   localparam int unsigned DVD_W  = SUM_W + 2;
   localparam int unsigned DVS_W  = SPP_W + 1;
   localparam int unsigned STEP_W = $clog2(DVD_W);

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_ERASE  = 3'd3,
      OP_READ   = 3'd4,
      OP_TICK   = 3'd5
   } op_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_NUM_POINTS        = 2'd0,
      CFG_SAMPLES_PER_POINT = 2'd1,
      CFG_REAL_TIME_PRESET  = 2'd2,
      CFG_LIVE_TIME_PRESET  = 2'd3
   } cfg_idx_type;

   typedef struct packed {
      logic accept;
      logic apply;
      logic sum_rd;
      logic sum_wr;
      logic div_rd;
      logic div_load;
      logic div_step;
      logic div_wr;
      logic close;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            running;
      logic            close_req;
   } sts_type;

endpackage

### rtl/asr_req_if.sv
// ----------------------------------------------------------------------------
// asr_req_if: input item channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface asr_req_if;
   import asr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [SIG_IDX_W-1:0] signal_index;
   logic                 last_in_set;
   logic [VAL_W-1:0]     sample_value;
   logic [PIDX_W-1:0]    point_index;

   modport source (output valid, op, signal_index, last_in_set, sample_value, point_index,
                   input ready);
   modport sink   (input valid, op, signal_index, last_in_set, sample_value, point_index,
                   output ready);
endinterface

### rtl/asr_rsp_if.sv
// ----------------------------------------------------------------------------
// asr_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface asr_rsp_if;
   import asr_pkg::*;

   logic               valid;
   logic               ready;
   logic [VAL_W-1:0]   read_data;
   logic               acquiring;
   logic [NPTS_W-1:0]  points_acquired;
   logic [TICK_W-1:0]  elapsed_ticks;
   logic               point_stored;
   logic               error;

   modport source (output valid, read_data, acquiring, points_acquired, elapsed_ticks,
                   point_stored, error, input ready);
   modport sink   (input valid, read_data, acquiring, points_acquired, elapsed_ticks,
                   point_stored, error, output ready);
endinterface

### rtl/asr_ctrl.sv
// ----------------------------------------------------------------------------
// asr_ctrl: sequencer of the averaging sweep recorder
// Walks one item through accumulate, per-signal divide and point close.
// ----------------------------------------------------------------------------
module asr_ctrl #(
   parameter int unsigned SIGNALS = asr_pkg::DEF_SIGNALS,
   localparam int unsigned SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  asr_pkg::sts_type  sts,
   output asr_pkg::cmd_type  cmd,
   output logic [SW-1:0]     sig_sel
);
   import asr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_SUM_RD, ST_SUM_WR, ST_DIV_RD, ST_DIV_LOAD,
      ST_DIV_RUN, ST_DIV_WR, ST_CLOSE, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SW-1:0]     sig_ff, sig_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      sig_in       = sig_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.apply = 1'b1;
            if (sts.op == OP_SAMPLE && sts.running) state_in = ST_SUM_RD;
            else state_in = ST_DONE;
         end
         ST_SUM_RD: begin
            cmd.sum_rd = 1'b1;
            state_in   = ST_SUM_WR;
         end
         ST_SUM_WR: begin
            cmd.sum_wr = 1'b1;
            if (sts.close_req) begin
               sig_in   = '0;
               state_in = ST_DIV_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_RD: begin
            cmd.div_rd = 1'b1;
            state_in   = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DVD_W - 1)) state_in = ST_DIV_WR;
            else step_in = step_ff + 1'b1;
         end
         ST_DIV_WR: begin
            cmd.div_wr = 1'b1;
            if (sig_ff == SW'(SIGNALS - 1)) begin
               state_in = ST_CLOSE;
            end else begin
               sig_in   = sig_ff + 1'b1;
               state_in = ST_DIV_RD;
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sig_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sig_ff       <= sig_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign sig_sel   = sig_ff;

endmodule

### rtl/asr_dp.sv
// ----------------------------------------------------------------------------
// asr_dp: datapath of the averaging sweep recorder
// Registers, sum and point memories, serial divider and result register.
// ----------------------------------------------------------------------------
module asr_dp #(
   parameter int unsigned SIGNALS = asr_pkg::DEF_SIGNALS,
   parameter int unsigned POINTS  = asr_pkg::DEF_POINTS,
   localparam int unsigned SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  asr_pkg::cmd_type                  cmd,
   input  logic [SW-1:0]                     sig_sel,
   output asr_pkg::sts_type                  sts,
   input  logic [asr_pkg::OP_W-1:0]          in_op,
   input  logic [asr_pkg::SIG_IDX_W-1:0]     in_signal_index,
   input  logic                              in_last_in_set,
   input  logic [asr_pkg::VAL_W-1:0]         in_sample_value,
   input  logic [asr_pkg::PIDX_W-1:0]        in_point_index,
   input  logic                              csr_we,
   input  logic [asr_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [asr_pkg::CFG_DATA_W-1:0]    csr_wdata,
   output logic [asr_pkg::VAL_W-1:0]         out_read_data,
   output logic                              out_acquiring,
   output logic [asr_pkg::NPTS_W-1:0]        out_points_acquired,
   output logic [asr_pkg::TICK_W-1:0]        out_elapsed_ticks,
   output logic                              out_point_stored,
   output logic                              out_error
);
   import asr_pkg::*;

   localparam int unsigned PCW  = $clog2(POINTS + 1);
   localparam int unsigned CMPW = (PCW > NPTS_W) ? PCW : NPTS_W;
   localparam int unsigned SAW  = $clog2(SIGNALS * POINTS);

   // configuration
   logic [NPTS_W-1:0] npts_ff;
   logic [SPP_W-1:0]  spp_ff;
   logic [TICK_W-1:0] rtp_ff, ltp_ff;

   // latched item
   logic [OP_W-1:0]      op_ff;
   logic [SIG_IDX_W-1:0] sig_ff;
   logic                 last_ff;
   logic [VAL_W-1:0]     val_ff;
   logic [PIDX_W-1:0]    pidx_ff;

   // acquisition state
   logic              running_ff;
   logic [PCW-1:0]    pc_ff;
   logic [TICK_W-1:0] ticks_ff, latch_ff;
   logic [SPP_W-1:0]  sets_ff;
   logic [SIGNALS-1:0] sum_vld_ff;
   logic              stored_ff;

   // memories and read registers
   logic [SUM_W-1:0] sum_mem [SIGNALS];
   logic [VAL_W-1:0] store_mem [SIGNALS * POINTS];
   logic [SUM_W-1:0] sum_rd_ff;
   logic             sum_rd_vld_ff;
   logic [VAL_W-1:0] store_rd_ff;

   // divider
   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff, rem_ff;
   logic [VAL_W-1:0] quo_ff;

   logic [CMPW-1:0]  lim, pc_x, pc_next_x;
   logic [PCW-1:0]   pc_next;
   logic             pc_room;
   logic [SPP_W-1:0] n_eff, sets_inc;
   logic             sig_ok, rd_ok, rd_hit;
   logic [SW-1:0]    sig_a, sum_ra;
   logic [SUM_W-1:0] sum_eff;
   logic [DVS_W:0]   trial;
   logic             ge;
   logic [SAW-1:0]   st_wa, st_ra;

   always_comb begin
      lim       = (CMPW'(npts_ff) > CMPW'(POINTS)) ? CMPW'(POINTS) : CMPW'(npts_ff);
      pc_x      = CMPW'(pc_ff);
      pc_room   = pc_x < CMPW'(POINTS);
      pc_next   = pc_room ? pc_ff + 1'b1 : pc_ff;
      pc_next_x = CMPW'(pc_next);
      n_eff     = (spp_ff == '0) ? SPP_W'(1) : spp_ff;
      sets_inc  = sets_ff + 1'b1;
      sig_ok    = 32'(sig_ff) < SIGNALS;
      rd_ok     = sig_ok && (CMPW'(pidx_ff) < lim);
      rd_hit    = rd_ok && (CMPW'(pidx_ff) < pc_x);
      sig_a     = SW'(sig_ff);
      sum_ra    = cmd.div_rd ? sig_sel : sig_a;
      sum_eff   = sum_rd_vld_ff ? sum_rd_ff : '0;
      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      ge        = trial >= {1'b0, dvs_ff};
      st_wa     = SAW'(int'(sig_sel) * POINTS + int'(pc_ff));
      st_ra     = SAW'(int'(sig_ff) * POINTS + int'(pidx_ff));
   end

   assign sts.op        = op_ff;
   assign sts.running   = running_ff;
   assign sts.close_req = last_ff && (sets_inc >= n_eff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         npts_ff    <= NPTS_W'(2048);
         spp_ff     <= SPP_W'(1);
         rtp_ff     <= '0;
         ltp_ff     <= '0;
         running_ff <= 1'b0;
         pc_ff      <= '0;
         ticks_ff   <= '0;
         latch_ff   <= '0;
         sets_ff    <= '0;
         sum_vld_ff <= '0;
         stored_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (cfg_idx_type'(csr_index))
               CFG_NUM_POINTS:        npts_ff <= csr_wdata[NPTS_W-1:0];
               CFG_SAMPLES_PER_POINT: begin
                  spp_ff     <= csr_wdata[SPP_W-1:0];
                  sets_ff    <= '0;
                  sum_vld_ff <= '0;
               end
               CFG_REAL_TIME_PRESET:  rtp_ff <= csr_wdata[TICK_W-1:0];
               CFG_LIVE_TIME_PRESET:  ltp_ff <= csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) stored_ff <= 1'b0;
         if (cmd.apply) begin
            if (op_ff == OP_START && !running_ff) begin
               running_ff <= 1'b1;
               ticks_ff   <= '0;
            end
            if (op_ff == OP_STOP) running_ff <= 1'b0;
            if (op_ff == OP_ERASE) begin
               pc_ff    <= '0;
               ticks_ff <= '0;
               latch_ff <= '0;
            end
            if (op_ff == OP_TICK && ticks_ff != '1) ticks_ff <= ticks_ff + 1'b1;
         end
         if (cmd.sum_wr) begin
            if (sig_ok) sum_vld_ff[sig_a] <= 1'b1;
            if (last_ff) sets_ff <= sets_inc;
         end
         if (cmd.close) begin
            stored_ff  <= pc_room;
            pc_ff      <= pc_next;
            latch_ff   <= ticks_ff;
            sets_ff    <= '0;
            sum_vld_ff <= '0;
            if (pc_next_x >= lim ||
                (rtp_ff != '0 && ticks_ff >= rtp_ff) ||
                (ltp_ff != '0 && ticks_ff >= ltp_ff)) running_ff <= 1'b0;
         end
      end
   end

   // item latch, memories, divider and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= in_op;
         sig_ff  <= in_signal_index;
         last_ff <= in_last_in_set;
         val_ff  <= in_sample_value;
         pidx_ff <= in_point_index;
      end
      if (cmd.sum_rd || cmd.div_rd) begin
         sum_rd_ff     <= sum_mem[sum_ra];
         sum_rd_vld_ff <= sum_vld_ff[sum_ra];
      end
      if (cmd.sum_wr && sig_ok) sum_mem[sig_a] <= sum_eff + SUM_W'(val_ff);
      if (cmd.apply && op_ff == OP_READ && rd_ok) store_rd_ff <= store_mem[st_ra];
      if (cmd.div_wr && pc_room) store_mem[st_wa] <= quo_ff;
      if (cmd.div_load) begin
         dvd_ff <= {1'b0, sum_eff, 1'b0} + DVD_W'(n_eff);
         dvs_ff <= {n_eff, 1'b0};
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         quo_ff <= {quo_ff[VAL_W-2:0], ge};
      end
      if (cmd.load_rsp) begin
         out_read_data       <= (op_ff == OP_READ && rd_hit) ? store_rd_ff : '0;
         out_acquiring       <= running_ff;
         out_points_acquired <= NPTS_W'(pc_ff);
         out_elapsed_ticks   <= latch_ff;
         out_point_stored    <= stored_ff;
         out_error           <= (op_ff == OP_READ) && !rd_ok;
      end
   end

endmodule

### rtl/averaging_sweep_recorder.sv
// ----------------------------------------------------------------------------
// averaging_sweep_recorder: multi-signal sweep recorder with averaging
// Sums sample elements per signal, averages each point and stores the sweep.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Start, stop, erase, tick,
// read, reserved ops and a sample element taken while stopped go from the
// execute step straight to the result; a sample element taken while acquiring
// first reads and writes its signal's sum. A sample element that closes a point
// runs the round-half-up average of every signal through one serial divider,
// one quotient bit per cycle over 49 bits. The next item is taken while a
// result waits on the output. Erase costs no sweep: the store is tracked by its
// fill count, so unwritten points read as zero, and no clearing pass follows
// reset.
module averaging_sweep_recorder #(
   parameter int unsigned SIGNALS = asr_pkg::DEF_SIGNALS,
   parameter int unsigned POINTS  = asr_pkg::DEF_POINTS
) (
   input  logic                           clock,
   input  logic                           reset,
   asr_req_if.sink                        req_ch,
   asr_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [asr_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [asr_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import asr_pkg::*;

   localparam int unsigned SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

   cmd_type       cmd;
   sts_type       sts;
   logic [SW-1:0] sig_sel;

   // sequencer: owns the handshakes and the divide loop counters
   asr_ctrl #(.SIGNALS(SIGNALS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd),
      .sig_sel   (sig_sel)
   );

   // datapath: config, sums, point store, divider, result register
   asr_dp #(.SIGNALS(SIGNALS), .POINTS(POINTS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sig_sel             (sig_sel),
      .sts                 (sts),
      .in_op               (req_ch.op),
      .in_signal_index     (req_ch.signal_index),
      .in_last_in_set      (req_ch.last_in_set),
      .in_sample_value     (req_ch.sample_value),
      .in_point_index      (req_ch.point_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .out_read_data       (rsp_ch.read_data),
      .out_acquiring       (rsp_ch.acquiring),
      .out_points_acquired (rsp_ch.points_acquired),
      .out_elapsed_ticks   (rsp_ch.elapsed_ticks),
      .out_point_stored    (rsp_ch.point_stored),
      .out_error           (rsp_ch.error)
   );

endmodule

### rtl/asr_checker.sv
// ----------------------------------------------------------------------------
// asr_checker: port-level checks of the averaging sweep recorder
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module asr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [asr_pkg::VAL_W-1:0]    rsp_read_data,
   input logic                         rsp_error,
   input logic                         rsp_point_stored,
   input logic [asr_pkg::NPTS_W-1:0]   rsp_points_acquired
);

   // one item in flight: no transfer in right after a transfer in
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_read_data == '0)
      else $error("failed read returned data");

   a_stored_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_stored |-> rsp_points_acquired != '0)
      else $error("point stored with zero point count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

endmodule

bind averaging_sweep_recorder asr_checker u_asr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_read_data       (rsp_ch.read_data),
   .rsp_error           (rsp_ch.error),
   .rsp_point_stored    (rsp_ch.point_stored),
   .rsp_points_acquired (rsp_ch.points_acquired)
);
